// ===== hdl/cpwm_pkg.sv =====
// Shared types and constants of the current-to-PWM curve interpolator.
`default_nettype none
package cpwm_pkg;
	localparam int CUR_W  = 16;
	localparam int PCT_W  = 8;
	localparam int IDX_W  = 6;
	localparam int NUM_W  = 23;
	localparam int FRAC_W = 16;
	localparam logic [PCT_W-1:0] PCT_MAX = 8'd100;
	localparam logic [6:0] DEN_PCT = 7'd100;

	typedef enum logic [1:0] {
		MODE_WRITE   = 2'd0,
		MODE_CURRENT = 2'd1,
		MODE_PCT_SET = 2'd2,
		MODE_PCT_MAX = 2'd3
	} mode_t;

	typedef struct packed {
		logic             is_write;
		logic [IDX_W-1:0] pidx;
		logic [CUR_W-1:0] pval;
		logic [NUM_W-1:0] num;
		logic             den_pct;
	} cmd_t;
endpackage
`default_nettype wire

// ===== hdl/cpwm_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module cpwm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 21
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end
endmodule
`default_nettype wire

// ===== hdl/cpwm_fifo.sv =====
// Small register queue with full and empty flags.
`default_nettype none
module cpwm_fifo #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/cpwm_front.sv =====
// Front end: classifies an input word and forms the query numerator.
`default_nettype none
module cpwm_front (
	input  wire logic                    push,
	input  wire logic [1:0]              mode,
	input  wire logic [5:0]              point_index,
	input  wire logic [15:0]             point_value,
	input  wire logic [15:0]             target_current,
	input  wire logic [7:0]              percent,
	input  wire logic [15:0]             set_current,
	input  wire logic [15:0]             cmax,
	output logic                         q_push,
	output cpwm_pkg::cmd_t               cmd
);
	import cpwm_pkg::*;

	logic [PCT_W-1:0]       pct_c;
	logic [PCT_W+CUR_W-1:0] prod_c;
	logic [CUR_W-1:0]       base_c;

	assign q_push = push;
	assign pct_c  = (percent > PCT_MAX) ? PCT_MAX : percent;
	assign base_c = (mode == MODE_PCT_SET) ? set_current : cmax;
	assign prod_c = (PCT_W+CUR_W)'(pct_c) * (PCT_W+CUR_W)'(base_c);

	always_comb begin
		cmd.pidx     = point_index;
		cmd.pval     = point_value;
		cmd.is_write = 1'b0;
		cmd.den_pct  = 1'b0;
		cmd.num      = '0;
		unique case (mode)
			MODE_WRITE: begin
				cmd.is_write = 1'b1;
			end
			MODE_CURRENT: begin
				cmd.num = NUM_W'(target_current);
			end
			MODE_PCT_SET, MODE_PCT_MAX: begin
				cmd.den_pct = 1'b1;
				cmd.num     = prod_c[NUM_W-1:0];
			end
			default: begin
				cmd.is_write = 1'b0;
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/cpwm_back.sv =====
// Back end: segment division, table read, interpolation and rounding division.
`default_nettype none
module cpwm_back #(
	parameter int POINTS = 21
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [15:0]            cmax,
	input  wire logic                   cmd_valid,
	input  wire cpwm_pkg::cmd_t         cmd,
	output logic                        cmd_pop,
	input  wire logic                   res_full,
	output logic                        res_push,
	output logic [15:0]                 res_data
);
	import cpwm_pkg::*;

	localparam int AW  = $clog2(POINTS);
	localparam int DW  = NUM_W;
	localparam int PW  = NUM_W + AW;
	localparam int N2W = DW + FRAC_W + 1;

	logic adv;
	assign adv     = !res_full;
	assign cmd_pop = adv && cmd_valid;

	// segment division, one quotient bit per stage
	logic             v_s1    [0:AW];
	logic             wr_s1   [0:AW];
	logic [IDX_W-1:0] pidx_s1 [0:AW];
	logic [CUR_W-1:0] pval_s1 [0:AW];
	logic             zero_s1 [0:AW];
	logic             sat_s1  [0:AW];
	logic [DW-1:0]    d_s1    [0:AW];
	logic [PW-1:0]    rem_s1  [0:AW];
	logic [AW-1:0]    q_s1    [0:AW];

	logic [DW-1:0] d_c;
	assign d_c = cmd.den_pct ? DW'(32'(cmax) * 32'(DEN_PCT)) : DW'(cmax);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1[0] <= 1'b0;
		end else if (adv) begin
			v_s1[0] <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wr_s1[0]   <= cmd.is_write;
			pidx_s1[0] <= cmd.pidx;
			pval_s1[0] <= cmd.pval;
			zero_s1[0] <= (cmd.num == '0) || (cmax == '0);
			sat_s1[0]  <= (cmd.num >= d_c);
			d_s1[0]    <= d_c;
			rem_s1[0]  <= PW'(cmd.num) * PW'(POINTS - 1);
			q_s1[0]    <= '0;
		end
	end

	for (genvar j = 1; j <= AW; j++) begin : g_div1
		logic [PW-1:0] sub_c;
		logic          ge_c;
		assign sub_c = PW'(d_s1[j-1]) << (AW - j);
		assign ge_c  = rem_s1[j-1] >= sub_c;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[j] <= 1'b0;
			end else if (adv) begin
				v_s1[j] <= v_s1[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				wr_s1[j]   <= wr_s1[j-1];
				pidx_s1[j] <= pidx_s1[j-1];
				pval_s1[j] <= pval_s1[j-1];
				zero_s1[j] <= zero_s1[j-1];
				sat_s1[j]  <= sat_s1[j-1];
				d_s1[j]    <= d_s1[j-1];
				rem_s1[j]  <= ge_c ? rem_s1[j-1] - sub_c : rem_s1[j-1];
				q_s1[j]    <= q_s1[j-1] | (ge_c ? AW'(1) << (AW - j) : '0);
			end
		end
	end

	// table access; writes and reads stay in word order
	logic [AW-1:0]    ra_c, rb_c;
	logic [CUR_W-1:0] a_rd, b_rd;
	logic             we_c;

	assign ra_c = sat_s1[AW] ? AW'(POINTS - 1) : q_s1[AW];
	assign rb_c = q_s1[AW] + 1'b1;
	assign we_c = adv && v_s1[AW] && wr_s1[AW] && (32'(pidx_s1[AW]) < POINTS);

	cpwm_ram #(
		.WIDTH (CUR_W),
		.DEPTH (POINTS)
	) u_ram (
		.clk     (clk),
		.we      (we_c),
		.waddr   (pidx_s1[AW][AW-1:0]),
		.wdata   (pval_s1[AW]),
		.re      (adv),
		.raddr_a (ra_c),
		.raddr_b (rb_c),
		.rdata_a (a_rd),
		.rdata_b (b_rd)
	);

	logic          v_s2, wr_s2, zero_s2, sat_s2;
	logic [DW-1:0] d_s2, rem_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1[AW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wr_s2   <= wr_s1[AW];
			zero_s2 <= zero_s1[AW];
			sat_s2  <= sat_s1[AW];
			d_s2    <= d_s1[AW];
			rem_s2  <= rem_s1[AW][DW-1:0];
		end
	end

	// rounding division of rem * (b - a) + D/2 by D
	logic             v_s3    [0:FRAC_W];
	logic             wr_s3   [0:FRAC_W];
	logic             zero_s3 [0:FRAC_W];
	logic             sat_s3  [0:FRAC_W];
	logic [DW-1:0]    d_s3    [0:FRAC_W];
	logic [CUR_W-1:0] a_s3    [0:FRAC_W];
	logic [N2W-1:0]   n_s3    [0:FRAC_W];
	logic [FRAC_W-1:0] q_s3   [0:FRAC_W];

	logic [CUR_W-1:0] diff_c;
	assign diff_c = b_rd - a_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3[0] <= 1'b0;
		end else if (adv) begin
			v_s3[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wr_s3[0]   <= wr_s2;
			zero_s3[0] <= zero_s2;
			sat_s3[0]  <= sat_s2;
			d_s3[0]    <= d_s2;
			a_s3[0]    <= a_rd;
			n_s3[0]    <= N2W'(rem_s2) * N2W'(diff_c) + N2W'(d_s2 >> 1);
			q_s3[0]    <= '0;
		end
	end

	for (genvar j = 1; j <= FRAC_W; j++) begin : g_div2
		logic [N2W-1:0] sub_c;
		logic           ge_c;
		assign sub_c = N2W'(d_s3[j-1]) << (FRAC_W - j);
		assign ge_c  = n_s3[j-1] >= sub_c;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3[j] <= 1'b0;
			end else if (adv) begin
				v_s3[j] <= v_s3[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				wr_s3[j]   <= wr_s3[j-1];
				zero_s3[j] <= zero_s3[j-1];
				sat_s3[j]  <= sat_s3[j-1];
				d_s3[j]    <= d_s3[j-1];
				a_s3[j]    <= a_s3[j-1];
				n_s3[j]    <= ge_c ? n_s3[j-1] - sub_c : n_s3[j-1];
				q_s3[j]    <= q_s3[j-1] | (ge_c ? FRAC_W'(1) << (FRAC_W - j) : '0);
			end
		end
	end

	assign res_push = adv && v_s3[FRAC_W] && !wr_s3[FRAC_W];

	always_comb begin
		priority if (zero_s3[FRAC_W]) begin
			res_data = '0;
		end else if (sat_s3[FRAC_W]) begin
			res_data = a_s3[FRAC_W];
		end else begin
			res_data = a_s3[FRAC_W] + q_s3[FRAC_W];
		end
	end
endmodule
`default_nettype wire

// ===== hdl/current_to_pwm_curve_interpolator.sv =====
// Top level of the current-to-PWM curve interpolator.
`default_nettype none
// Piecewise linear map from current to PWM counts over a table of POINTS
// entries. Words enter through a four-deep queue and leave through a two-deep
// result queue; one word a cycle is taken as long as results are popped.
// A query passes through one pipeline stage per bit of the segment division
// and per bit of the 16-bit rounding division, plus setup, table read and
// multiply stages, before its result enters the result queue.
// Table writes (mode 0) run through the same pipeline and give no result.
module current_to_pwm_curve_interpolator #(
	parameter int POINTS = 21
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  mode,
	input  wire logic [5:0]  point_index,
	input  wire logic [15:0] point_value,
	input  wire logic [15:0] target_current,
	input  wire logic [7:0]  percent,
	input  wire logic [15:0] set_current,
	input  wire logic        pop,
	output logic             empty,
	output logic [15:0]      pwm_counts,
	input  wire logic        calib_we,
	input  wire logic [15:0] calib_wdata
);
	import cpwm_pkg::*;

	logic [CUR_W-1:0] cmax_q;
	logic             q_push, q_empty, cmd_pop, res_push, res_full;
	cmd_t             cmd_in, cmd_out;
	logic [CUR_W-1:0] res_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmax_q <= '0;
		end else if (calib_we) begin
			cmax_q <= calib_wdata;
		end
	end

	cpwm_front u_front (
		.push           (push),
		.mode           (mode),
		.point_index    (point_index),
		.point_value    (point_value),
		.target_current (target_current),
		.percent        (percent),
		.set_current    (set_current),
		.cmax           (cmax_q),
		.q_push         (q_push),
		.cmd            (cmd_in)
	);

	cpwm_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (4)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (q_empty)
	);

	cpwm_back #(
		.POINTS (POINTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmax      (cmax_q),
		.cmd_valid (!q_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	cpwm_fifo #(
		.WIDTH (CUR_W),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_data),
		.full   (res_full),
		.pop    (pop),
		.rdata  (pwm_counts),
		.empty  (empty)
	);

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result word pushed into full queue");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !q_empty) else $error("command popped from empty queue");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_full |-> !cmd_pop) else $error("back end advanced while stalled");
`endif
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the current-to-PWM curve interpolator.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cpwm_pkg::*;

	localparam int NPTS = 21;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT = 3000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [1:0] mode;
	logic [5:0] point_index;
	logic [15:0] point_value;
	logic [15:0] target_current;
	logic [7:0] percent;
	logic [15:0] set_current;
	logic pop;
	logic empty;
	logic [15:0] pwm_counts;
	logic calib_we;
	logic [15:0] calib_wdata;

	logic [15:0] curve_model [NPTS];
	logic [15:0] calib_model;
	logic [15:0] pwm_expected_q [$];
	int fail_count;
	int stall_cycles;
	bit steady;
	bit in_accepted;
	bit out_accepted;

	current_to_pwm_curve_interpolator #(.POINTS(NPTS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.mode(mode),
		.point_index(point_index),
		.point_value(point_value),
		.target_current(target_current),
		.percent(percent),
		.set_current(set_current),
		.pop(pop),
		.empty(empty),
		.pwm_counts(pwm_counts),
		.calib_we(calib_we),
		.calib_wdata(calib_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Interpolate over the mirrored curve for a target of num/den.
	function automatic logic [15:0] interp_pwm(longint unsigned num, longint unsigned den);
		longint unsigned span, pos, seg, rem, diff, frac;
		logic [15:0] a, b;
		span = den * longint'(calib_model);
		if (num == 0 || calib_model == 0)
			return 16'd0;
		if (num >= span)
			return curve_model[NPTS-1];
		pos = num * (NPTS - 1);
		seg = pos / span;
		rem = pos % span;
		a = curve_model[seg];
		b = curve_model[seg+1];
		diff = 16'(b - a);
		frac = (rem * diff + span / 2) / span;
		return 16'(longint'(a) + frac);
	endfunction

	function automatic void model_word(mode_t m, logic [5:0] idx, logic [15:0] val,
			logic [15:0] tcur, logic [7:0] pct, logic [15:0] scur);
		longint unsigned p;
		p = (pct > PCT_MAX) ? 100 : pct;
		case (m)
			MODE_WRITE: begin
				if (idx < NPTS)
					curve_model[idx] = val;
			end
			MODE_CURRENT: pwm_expected_q.push_back(interp_pwm(tcur, 1));
			MODE_PCT_SET: pwm_expected_q.push_back(interp_pwm(p * scur, 100));
			default: pwm_expected_q.push_back(interp_pwm(p * calib_model, 100));
		endcase
	endfunction

	task automatic send_word(mode_t m, logic [5:0] idx, logic [15:0] val,
			logic [15:0] tcur, logic [7:0] pct, logic [15:0] scur);
		bit ok;
		if (!steady && $urandom_range(99) < 27) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		mode <= m;
		point_index <= idx;
		point_value <= val;
		target_current <= tcur;
		percent <= pct;
		set_current <= scur;
		do begin
			@(negedge clk);
			ok = !full;
			@(posedge clk);
		end while (!ok);
		model_word(m, idx, val, tcur, pct, scur);
	endtask

	// Drain results and in-flight table writes, then load the calibration.
	task automatic set_calibration(logic [15:0] value);
		push <= 1'b0;
		while (pwm_expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		calib_we <= 1'b1;
		calib_wdata <= value;
		@(posedge clk);
		calib_we <= 1'b0;
		calib_model = value;
	endtask

	task automatic test_fill_curve();
		for (int i = 0; i < NPTS; i++)
			send_word(MODE_WRITE, 6'(i), 16'(i * 3000 + $urandom_range(2999)),
				16'($urandom), 8'($urandom), 16'($urandom));
	endtask

	task automatic test_directed();
		set_calibration(16'd1000);
		send_word(MODE_CURRENT, 6'd0, 16'd0, 16'd0, 8'd0, 16'd0);
		send_word(MODE_CURRENT, 6'd0, 16'd0, 16'hFFFF, 8'd0, 16'd0);
		send_word(MODE_CURRENT, 6'd0, 16'd0, 16'd999, 8'd0, 16'd0);
		send_word(MODE_CURRENT, 6'd0, 16'd0, 16'd1000, 8'd0, 16'd0);
		send_word(MODE_CURRENT, 6'd0, 16'd0, 16'd1, 8'd0, 16'd0);
		send_word(MODE_CURRENT, 6'd0, 16'd0, 16'd525, 8'd0, 16'd0);
		send_word(MODE_PCT_SET, 6'd0, 16'd0, 16'd0, 8'd0, 16'hFFFF);
		send_word(MODE_PCT_SET, 6'd0, 16'd0, 16'd0, 8'hFF, 16'hFFFF);
		send_word(MODE_PCT_SET, 6'd0, 16'd0, 16'd0, 8'd100, 16'd999);
		send_word(MODE_PCT_SET, 6'd0, 16'd0, 16'd0, 8'd37, 16'd800);
		send_word(MODE_PCT_MAX, 6'd0, 16'd0, 16'd0, 8'd50, 16'd0);
		send_word(MODE_PCT_MAX, 6'd0, 16'd0, 16'd0, 8'd101, 16'd0);
		send_word(MODE_PCT_MAX, 6'd0, 16'd0, 16'd0, 8'd0, 16'd0);
		// out-of-range index must leave the curve alone
		send_word(MODE_WRITE, 6'd63, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
		send_word(MODE_WRITE, 6'd21, 16'd0, 16'd0, 8'd0, 16'd0);
		send_word(MODE_CURRENT, 6'd0, 16'd0, 16'd1000, 8'd0, 16'd0);
		// descending segment between points 5 and 6
		send_word(MODE_WRITE, 6'd6, 16'd10, 16'd0, 8'd0, 16'd0);
		send_word(MODE_CURRENT, 6'd0, 16'd0, 16'd290, 8'd0, 16'd0);
		send_word(MODE_CURRENT, 6'd0, 16'd0, 16'd274, 8'd0, 16'd0);
		send_word(MODE_WRITE, 6'd20, 16'hFFFF, 16'd0, 8'd0, 16'd0);
		send_word(MODE_CURRENT, 6'd0, 16'd0, 16'd999, 8'd0, 16'd0);
		send_word(MODE_CURRENT, 6'd0, 16'd0, 16'd1000, 8'd0, 16'd0);
	endtask

	task automatic test_random(logic [15:0] cal, int count);
		mode_t m;
		logic [5:0] idx;
		logic [15:0] val, tcur, scur;
		logic [7:0] pct;
		int span;
		set_calibration(cal);
		span = int'(cal) + int'(cal) / 8 + 2;
		for (int n = 0; n < count; n++) begin
			m = mode_t'($urandom_range(1, 3));
			idx = 6'($urandom);
			val = 16'($urandom);
			tcur = 16'($urandom);
			pct = 8'($urandom);
			scur = 16'($urandom);
			if ($urandom_range(99) < 10) begin
				m = MODE_WRITE;
				// mostly keep the curve increasing
				if (idx < NPTS && $urandom_range(99) < 80)
					val = 16'(int'(idx) * 3000 + $urandom_range(2999));
			end else if ($urandom_range(99) < 85) begin
				tcur = 16'($urandom_range(0, span > 65535 ? 65535 : span));
				pct = 8'($urandom_range(0, 110));
				scur = 16'($urandom_range(0, span > 65535 ? 65535 : span));
			end
			send_word(m, idx, val, tcur, pct, scur);
		end
	endtask

	always @(posedge clk)
		pop <= arst_n && (steady || $urandom_range(99) >= 27);

	always @(negedge clk) begin
		in_accepted <= push && !full;
		out_accepted <= pop && !empty;
		if (arst_n && pop && !empty) begin
			if (pwm_expected_q.size() == 0) begin
				$error("pwm_counts: no result expected, actual %0d", pwm_counts);
				fail_count++;
			end else begin
				if (pwm_counts !== pwm_expected_q[0]) begin
					$error("pwm_counts: expected %0d, actual %0d",
						pwm_expected_q[0], pwm_counts);
					fail_count++;
				end
				void'(pwm_expected_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (in_accepted || out_accepted || calib_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("current_to_pwm_curve_interpolator: mismatch");
			$finish;
		end
	end

	initial begin
		fail_count = 0;
		stall_cycles = 0;
		steady = 1'b0;
		calib_model = 16'd0;
		arst_n <= 1'b0;
		push <= 1'b0;
		mode <= MODE_WRITE;
		point_index <= '0;
		point_value <= '0;
		target_current <= '0;
		percent <= '0;
		set_current <= '0;
		calib_we <= 1'b0;
		calib_wdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_curve();
		test_directed();
		test_random(16'd1000, 200);
		test_random(16'hFFFF, 200);
		test_random(16'd1, 150);
		steady = 1'b1;
		test_random(16'd20, 200);
		steady = 1'b0;
		test_random(16'd0, 100);
		test_random(16'($urandom_range(2, 65534)), 200);
		test_random(16'd3777, 180);
		push <= 1'b0;
		while (pwm_expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("current_to_pwm_curve_interpolator: match");
		else
			$display("current_to_pwm_curve_interpolator: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/cpwm_pkg.sv
hdl/cpwm_ram.sv
hdl/cpwm_fifo.sv
hdl/cpwm_front.sv
hdl/cpwm_back.sv
hdl/current_to_pwm_curve_interpolator.sv
tb/testbench.sv
